// ----- design/gsp_pkg.sv -----
// Shared types, register map and saturating time arithmetic for the gait
// support phase unit. No dependencies; imported by gait_support_phase_fsm_unit.
package gsp_pkg;

   localparam int TimeWidth  = 32;
   localparam int SpanWidth  = 25;   // sum of two 24-bit periods
   localparam int CsrAddrW   = 5;
   localparam int CsrDataW   = 32;

   // Register indexes on the configuration port (byte address is 4 * index).
   typedef enum logic [2:0] {
      CSR_DS_PERIOD       = 3'd0,
      CSR_SS_PERIOD       = 3'd1,
      CSR_TRANS_DS_PERIOD = 3'd2,
      CSR_HALF_RECOMPUTE  = 3'd3,
      CSR_STEPS_BEFORE_DS = 3'd4,
      CSR_VEL_THRESHOLD   = 3'd5,
      CSR_TIME_TOLERANCE  = 3'd6
   } csr_index_type;

   localparam logic [23:0] DsPeriodReset      = 24'd100000;
   localparam logic [23:0] SsPeriodReset      = 24'd700000;
   localparam logic [23:0] TransDsPeriodReset = 24'd100000;
   localparam logic [23:0] HalfRecomputeReset = 24'd50000;
   localparam logic [7:0]  StepsBeforeDsReset = 8'd2;
   localparam logic [14:0] VelThresholdReset  = 15'd1;
   localparam logic [15:0] TimeToleranceReset = 16'd1;

   typedef enum logic {
      PHASE_DS = 1'b0,
      PHASE_SS = 1'b1
   } phase_type;

   typedef enum logic [1:0] {
      MOVE_NONE,
      MOVE_TO_DS,
      MOVE_TO_SS,
      MOVE_SWAP
   } move_type;

   typedef struct packed {
      logic [31:0]        sample_time;
      logic [31:0]        ds_limit_time;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_yaw;
   } req_type;

   typedef struct packed {
      logic        phase;
      logic        stance_foot;
      logic        changed;
      logic        in_transition;
      logic [7:0]  steps_left;
      logic [15:0] step_count;
      logic [15:0] instants;
      logic [31:0] phase_start;
      logic [31:0] phase_limit;
   } rsp_type;

   // Time sum that sticks at the largest count instead of wrapping.
   function automatic logic [TimeWidth-1:0] sat_add(input logic [TimeWidth-1:0] a,
                                                    input logic [SpanWidth-1:0] b);
      logic [TimeWidth:0] s;
      s = {1'b0, a} + {{(TimeWidth + 1 - SpanWidth){1'b0}}, b};
      return s[TimeWidth] ? {TimeWidth{1'b1}} : s[TimeWidth-1:0];
   endfunction

   // True when the magnitude of a signed sample exceeds the threshold.
   // The most negative value has magnitude 32768 and is handled in 17 bits.
   function automatic logic over_threshold(input logic [15:0] v,
                                           input logic [14:0] thr);
      logic [16:0] mag;
      mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
      return mag > {2'b00, thr};
   endfunction

endpackage

// ----- design/gait_support_phase_fsm_unit.sv -----
// Top level of the gait support phase unit: configuration registers, input
// register, support phase state machine and result register.
// Depends on gsp_pkg.
//
//  Channel  Direction  Handshake                 Beat contents
//  req      in         req_valid / req_ready     req_type: time, horizon, velocity
//  rsp      out        rsp_valid / rsp_ready     rsp_type: phase state after the item
//  csr      in/out     APB csr_psel / penable    seven registers at 4 * index
//
// A beat accepted into the input register runs through the phase update there
// and is loaded into the result register when the update stage advances, from
// where its result can be taken.
// A new beat is accepted every cycle while results are taken; the phase update
// on the registered state is combinational.
// Reset is synchronous and active high; it restores the register defaults
// and puts the walker in double support on the left foot with all counts zero.
// A result not taken holds the input register, and req_ready then falls.
module gait_support_phase_fsm_unit
   import gsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes land on the access cycle; pready is
   // tied high so every transfer completes without wait states.
   // ---------------------------------------------------------------------
   logic [23:0] ds_period_ff, ss_period_ff, trans_ds_period_ff, half_recompute_ff;
   logic [7:0]  steps_before_ds_ff;
   logic [14:0] vel_threshold_ff;
   logic [15:0] time_tolerance_ff;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CsrAddrW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_period_ff       <= DsPeriodReset;
         ss_period_ff       <= SsPeriodReset;
         trans_ds_period_ff <= TransDsPeriodReset;
         half_recompute_ff  <= HalfRecomputeReset;
         steps_before_ds_ff <= StepsBeforeDsReset;
         vel_threshold_ff   <= VelThresholdReset;
         time_tolerance_ff  <= TimeToleranceReset;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DS_PERIOD:       ds_period_ff       <= csr_pwdata[23:0];
            CSR_SS_PERIOD:       ss_period_ff       <= csr_pwdata[23:0];
            CSR_TRANS_DS_PERIOD: trans_ds_period_ff <= csr_pwdata[23:0];
            CSR_HALF_RECOMPUTE:  half_recompute_ff  <= csr_pwdata[23:0];
            CSR_STEPS_BEFORE_DS: steps_before_ds_ff <= csr_pwdata[7:0];
            CSR_VEL_THRESHOLD:   vel_threshold_ff   <= csr_pwdata[14:0];
            CSR_TIME_TOLERANCE:  time_tolerance_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DS_PERIOD:       csr_prdata = {8'd0, ds_period_ff};
         CSR_SS_PERIOD:       csr_prdata = {8'd0, ss_period_ff};
         CSR_TRANS_DS_PERIOD: csr_prdata = {8'd0, trans_ds_period_ff};
         CSR_HALF_RECOMPUTE:  csr_prdata = {8'd0, half_recompute_ff};
         CSR_STEPS_BEFORE_DS: csr_prdata = {24'd0, steps_before_ds_ff};
         CSR_VEL_THRESHOLD:   csr_prdata = {17'd0, vel_threshold_ff};
         CSR_TIME_TOLERANCE:  csr_prdata = {16'd0, time_tolerance_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // Spans built from pairs of registers; the user is to keep them steady while beats flow (not enforced here).
   logic [SpanWidth-1:0] step_len;
   logic [SpanWidth-1:0] trans_tol;
   assign step_len  = {1'b0, trans_ds_period_ff} + {1'b0, ss_period_ff};
   assign trans_tol = {1'b0, trans_ds_period_ff} + {9'd0, time_tolerance_ff};

   // ---------------------------------------------------------------------
   // Input register. The reference test and the horizon plus tolerance are
   // formed on the way in, so the update stage only sees three time values
   // and one flag from the beat.
   // ---------------------------------------------------------------------
   logic                 in_valid_ff, in_valid_in;
   logic [TimeWidth-1:0] sample_time_ff;
   logic [TimeWidth-1:0] horizon_ff;
   logic [TimeWidth-1:0] horizon_tol_ff;
   logic                 given_ff;
   logic                 given_now;
   logic                 advance;
   logic                 req_accept;

   assign given_now = over_threshold(req_data.vel_x,   vel_threshold_ff) |
                      over_threshold(req_data.vel_y,   vel_threshold_ff) |
                      over_threshold(req_data.vel_yaw, vel_threshold_ff);

   // The update stage moves whenever the result register is free or is
   // being emptied in this cycle.
   assign advance    = in_valid_ff & (~rsp_valid | rsp_ready);
   assign req_ready  = ~in_valid_ff | advance;
   assign req_accept = req_valid & req_ready;
   assign in_valid_in = req_accept | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_time_ff <= req_data.sample_time;
         horizon_ff     <= req_data.ds_limit_time;
         horizon_tol_ff <= sat_add(req_data.ds_limit_time,
                                   {9'd0, time_tolerance_ff});
         given_ff       <= given_now;
      end
   end

   // ---------------------------------------------------------------------
   // Walking state.
   // ---------------------------------------------------------------------
   phase_type            phase_ff, phase_in;
   logic                 foot_ff, foot_in;
   logic [TimeWidth-1:0] limit_ff, limit_in;
   logic [TimeWidth-1:0] start_ff, start_in;
   logic [7:0]           steps_left_ff, steps_left_in;
   logic [15:0]          step_number_ff, step_number_in;
   logic [15:0]          instants_ff, instants_in;
   logic                 trans_flag_ff, trans_flag_in;

   // A late limit in double support is pulled in to the horizon when a
   // reference is present; the step budget is refilled at the same time.
   logic                 pull_in;
   logic [TimeWidth-1:0] limit_pulled;
   logic [7:0]           steps_pulled;
   logic                 switch_due;
   move_type             move;

   assign pull_in      = given_ff & (phase_ff == PHASE_DS) & (limit_ff > horizon_tol_ff);
   assign limit_pulled = pull_in ? horizon_ff : limit_ff;
   assign steps_pulled = pull_in ? steps_before_ds_ff : steps_left_ff;
   assign switch_due   = sample_time_ff >= sat_add(limit_pulled, {1'b0, half_recompute_ff});

   // Next phase: pick the transition, if any.
   always_comb begin
      move     = MOVE_NONE;
      phase_in = phase_ff;
      if (switch_due) begin
         if (phase_ff == PHASE_SS && !given_ff && steps_pulled == 8'd0) begin
            move     = MOVE_TO_DS;
            phase_in = PHASE_DS;
         end else if (phase_ff == PHASE_DS && (given_ff || steps_pulled != 8'd0)) begin
            move     = MOVE_TO_SS;
            phase_in = PHASE_SS;
         end else if ((phase_ff == PHASE_SS && steps_pulled != 8'd0) ||
                      (steps_pulled == 8'd0 && given_ff)) begin
            move = MOVE_SWAP;
         end
      end
   end

   // Data that follows from the chosen transition.
   logic                 changed;
   logic [TimeWidth-1:0] lim_plus_ds;
   logic [TimeWidth-1:0] lim_plus_step;
   logic [TimeWidth-1:0] trans_end_old;
   logic [TimeWidth-1:0] trans_end_new;
   logic                 trans_over;

   assign lim_plus_ds   = sat_add(limit_pulled, {1'b0, ds_period_ff});
   assign lim_plus_step = sat_add(limit_pulled, step_len);
   assign trans_end_old = sat_add(start_ff, trans_tol);
   assign trans_end_new = sat_add(limit_pulled, trans_tol);

   always_comb begin
      changed        = 1'b0;
      foot_in        = foot_ff;
      limit_in       = limit_pulled;
      start_in       = start_ff;
      steps_left_in  = steps_pulled;
      step_number_in = step_number_ff;
      trans_flag_in  = trans_flag_ff;
      case (move)
         MOVE_TO_DS: begin
            changed  = 1'b1;
            start_in = limit_pulled;
            limit_in = lim_plus_ds;
         end
         MOVE_TO_SS: begin
            changed       = 1'b1;
            start_in      = limit_pulled;
            limit_in      = lim_plus_step;
            steps_left_in = steps_before_ds_ff;
         end
         MOVE_SWAP: begin
            changed        = 1'b1;
            foot_in        = ~foot_ff;
            trans_flag_in  = 1'b1;
            start_in       = limit_pulled;
            limit_in       = lim_plus_step;
            step_number_in = step_number_ff + 16'd1;
            steps_left_in  = given_ff ? steps_before_ds_ff : steps_pulled - 8'd1;
         end
         default: ;
      endcase

      // The transitional flag ends once the sample time is past the start of the
      // phase now in force plus the transitional period and the tolerance.
      trans_over = sample_time_ff > (changed ? trans_end_new : trans_end_old);
      if (trans_over) begin
         trans_flag_in = 1'b0;
      end

      if (changed) begin
         instants_in = 16'd0;
      end else if (instants_ff != 16'hFFFF) begin
         instants_in = instants_ff + 16'd1;
      end else begin
         instants_in = instants_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_DS;
         foot_ff        <= 1'b0;
         limit_ff       <= '0;
         start_ff       <= '0;
         steps_left_ff  <= '0;
         step_number_ff <= '0;
         instants_ff    <= '0;
         trans_flag_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         foot_ff        <= foot_in;
         limit_ff       <= limit_in;
         start_ff       <= start_in;
         steps_left_ff  <= steps_left_in;
         step_number_ff <= step_number_in;
         instants_ff    <= instants_in;
         trans_flag_ff  <= trans_flag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register. It holds a beat until the consumer takes it, while
   // the input register can still take one beat behind it.
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_comb begin
      rsp_data_in.phase         = phase_in;
      rsp_data_in.stance_foot   = foot_in;
      rsp_data_in.changed       = changed;
      rsp_data_in.in_transition = trans_flag_in;
      rsp_data_in.steps_left    = steps_left_in;
      rsp_data_in.step_count    = step_number_in;
      rsp_data_in.instants      = instants_in;
      rsp_data_in.phase_start   = start_in;
      rsp_data_in.phase_limit   = limit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A transition always restarts the instant count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.changed || rsp_data_ff.instants == 16'd0))
      else $error("transition beat with nonzero instant count");

   // A held result must never be overwritten by the update stage.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("update stage moved while result was held");

   // The walking state only moves when a beat passes the update stage.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(limit_ff) && $stable(start_ff) && $stable(steps_left_ff)))
      else $error("walking state changed without a beat");

   // Every foot swap counts one step and every counted step swaps the foot.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> ((step_number_ff != $past(step_number_ff)) ==
                   (foot_ff != $past(foot_ff))))
      else $error("step count and stance foot out of step");
`endif

endmodule

// ----- verif/gsp_phase_checker.sv -----
// Scoreboard for the gait support phase unit: follows register writes, predicts
// one result beat per accepted request beat and compares them in order.
// Depends on gsp_pkg for the beat types, register indexes and reset values.
module gsp_phase_checker
   import gsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_data,

   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_data,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   input  logic                csr_pready,

   output int                  outstanding,
   output int                  mismatches,
   output int                  transitions,
   output logic [31:0]         predicted_limit
);
   timeunit 1ns;
   timeprecision 1ps;

   // Walker state as the unit should hold it.
   phase_type   cur_phase;
   logic        right_foot;
   logic [31:0] limit_us;
   logic [31:0] start_us;
   logic [7:0]  steps_left;
   logic [15:0] step_no;
   logic [15:0] instants;
   logic        in_trans;

   // Register copies.
   logic [23:0] ds_us;
   logic [23:0] ss_us;
   logic [23:0] trans_us;
   logic [23:0] half_us;
   logic [7:0]  steps_cfg;
   logic [14:0] vel_thr;
   logic [15:0] tol_us;

   rsp_type     phase_q[$];
   int          rsp_beats;

   function automatic logic [31:0] time_plus(input logic [31:0] a, input logic [33:0] b);
      logic [34:0] s;
      s = {3'b000, a} + {1'b0, b};
      return (s > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic bit moving(input logic [15:0] v);
      logic [16:0] mag;
      mag = v[15] ? ({1'b0, ~v} + 17'd1) : {1'b0, v};
      return mag > {2'b00, vel_thr};
   endfunction

   // Applies one request beat to the walker state and returns the result beat.
   function automatic rsp_type advance_phase(input req_type r);
      bit          ref_given;
      logic        swapped;
      logic [24:0] step_len;
      rsp_type     o;
      step_len  = {1'b0, trans_us} + {1'b0, ss_us};
      ref_given = moving(r.vel_x) || moving(r.vel_y) || moving(r.vel_yaw);
      swapped   = 1'b0;
      if (instants != 16'hFFFF) instants = instants + 16'd1;

      // A late limit is pulled in to the horizon while standing with a reference.
      if (ref_given && cur_phase == PHASE_DS &&
          limit_us > time_plus(r.ds_limit_time, {18'd0, tol_us})) begin
         limit_us   = r.ds_limit_time;
         steps_left = steps_cfg;
      end

      if (r.sample_time >= time_plus(limit_us, {10'd0, half_us})) begin
         if (cur_phase == PHASE_SS && !ref_given && steps_left == 8'd0) begin
            cur_phase = PHASE_DS;
            start_us  = limit_us;
            limit_us  = time_plus(limit_us, {10'd0, ds_us});
            swapped   = 1'b1;
            instants  = '0;
         end else if (cur_phase == PHASE_DS && (ref_given || steps_left != 8'd0)) begin
            cur_phase  = PHASE_SS;
            start_us   = limit_us;
            limit_us   = time_plus(limit_us, {9'd0, step_len});
            steps_left = steps_cfg;
            swapped    = 1'b1;
            instants   = '0;
         end else if ((cur_phase == PHASE_SS && steps_left != 8'd0) ||
                      (steps_left == 8'd0 && ref_given)) begin
            right_foot = ~right_foot;
            swapped    = 1'b1;
            instants   = '0;
            in_trans   = 1'b1;
            start_us   = limit_us;
            limit_us   = time_plus(limit_us, {9'd0, step_len});
            step_no    = step_no + 16'd1;
            steps_left = ref_given ? steps_cfg : steps_left - 8'd1;
         end
      end

      if (r.sample_time > time_plus(start_us, {10'd0, trans_us} + {18'd0, tol_us}))
         in_trans = 1'b0;

      if (swapped) transitions++;
      o.phase         = cur_phase;
      o.stance_foot   = right_foot;
      o.changed       = swapped;
      o.in_transition = in_trans;
      o.steps_left    = steps_left;
      o.step_count    = step_no;
      o.instants      = instants;
      o.phase_start   = start_us;
      o.phase_limit   = limit_us;
      return o;
   endfunction

   // Every mismatch is printed on one line and counted.
   task automatic report(input string what);
      $display("[%0t] mismatch on result beat %0d: %s", $time, rsp_beats, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cur_phase   = PHASE_DS;
         right_foot  = 1'b0;
         limit_us    = '0;
         start_us    = '0;
         steps_left  = '0;
         step_no     = '0;
         instants    = '0;
         in_trans    = 1'b0;
         ds_us       = DsPeriodReset;
         ss_us       = SsPeriodReset;
         trans_us    = TransDsPeriodReset;
         half_us     = HalfRecomputeReset;
         steps_cfg   = StepsBeforeDsReset;
         vel_thr     = VelThresholdReset;
         tol_us      = TimeToleranceReset;
         phase_q.delete();
         rsp_beats   = 0;
         mismatches  = 0;
         transitions = 0;
         outstanding     <= 0;
         predicted_limit <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CsrAddrW-1:2])
               CSR_DS_PERIOD:       ds_us     = csr_pwdata[23:0];
               CSR_SS_PERIOD:       ss_us     = csr_pwdata[23:0];
               CSR_TRANS_DS_PERIOD: trans_us  = csr_pwdata[23:0];
               CSR_HALF_RECOMPUTE:  half_us   = csr_pwdata[23:0];
               CSR_STEPS_BEFORE_DS: steps_cfg = csr_pwdata[7:0];
               CSR_VEL_THRESHOLD:   vel_thr   = csr_pwdata[14:0];
               CSR_TIME_TOLERANCE:  tol_us    = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            phase_q.push_back(advance_phase(req_data));
         if (rsp_valid && rsp_ready) begin
            if (phase_q.size() == 0) begin
               report("result beat arrived with nothing expected");
            end else begin
               want = phase_q.pop_front();
               check_field("phase", 64'(rsp_data.phase), 64'(want.phase));
               check_field("stance_foot", 64'(rsp_data.stance_foot),
                           64'(want.stance_foot));
               check_field("changed", 64'(rsp_data.changed), 64'(want.changed));
               check_field("in_transition", 64'(rsp_data.in_transition),
                           64'(want.in_transition));
               check_field("steps_left", 64'(rsp_data.steps_left),
                           64'(want.steps_left));
               check_field("step_count", 64'(rsp_data.step_count),
                           64'(want.step_count));
               check_field("instants", 64'(rsp_data.instants), 64'(want.instants));
               check_field("phase_start", 64'(rsp_data.phase_start),
                           64'(want.phase_start));
               check_field("phase_limit", 64'(rsp_data.phase_limit),
                           64'(want.phase_limit));
            end
            rsp_beats++;
         end
         outstanding     <= phase_q.size();
         predicted_limit <= limit_us;
      end
   end

endmodule

// ----- verif/testbench.sv -----
// Top of the gait support phase testbench: clock, reset, request and register
// stimulus, result-side backpressure and the verdict. Instantiates
// gait_support_phase_fsm_unit and gsp_phase_checker; depends on gsp_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gsp_pkg::*;

   localparam int     HalfPeriod   = 10;
   localparam int     ResetCycles  = 8;
   localparam int     RandomBeats  = 1500;
   localparam int     SettingCount = 8;
   localparam int     SoakBeats    = 20;      // length of each closing directed run
   localparam int     HoldCycles   = 300;
   localparam int     CsrUnmapped  = 7;       // first index past the register map
   localparam longint RunLimitNs   = 64'd20_000_000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   int                  outstanding;
   int                  mismatches;
   int                  transitions;
   logic [31:0]         predicted_limit;

   // Stimulus shaping: our own view of the threshold and of the time span of one
   // full walking cycle, plus the running sample time of the current sequence.
   logic [14:0]         cfg_thr;
   longint              span_us;
   logic [31:0]         now_us;
   int                  beats_sent    = 0;
   int                  settings_done = 0;
   int                  req_gap_pct   = 20;
   int                  rsp_stall_pct = 20;
   bit                  hold_request  = 1'b0;

   gait_support_phase_fsm_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gsp_phase_checker phase_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .outstanding     (outstanding),
      .mismatches      (mismatches),
      .transitions     (transitions),
      .predicted_limit (predicted_limit)
   );

   initial clock = 1'b0;
   always #HalfPeriod clock = ~clock;

   // Hard ceiling on the run. A correct run ends far earlier.
   initial begin
      #(RunLimitNs);
      $display("FAIL gait_support_phase_fsm_unit");
      $finish;
   end

   // Idle stretches: mostly short, now and then a long one.
   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] later(input logic [31:0] t, input longint d);
      longint s;
      s = longint'(t) + d;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // One velocity component either above or at most at the threshold. A quarter
   // of the picks land right on the boundary; magnitude 32768 gives the most
   // negative value.
   function automatic logic signed [15:0] pick_vel(input bit above);
      int          mag;
      logic [15:0] v;
      if (above)
         mag = ($urandom_range(0, 3) == 0) ? int'(cfg_thr) + 1
                                          : $urandom_range(int'(cfg_thr) + 1, 32768);
      else
         mag = ($urandom_range(0, 3) == 0) ? int'(cfg_thr) : $urandom_range(0, cfg_thr);
      v = mag[15:0];
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // Result side. A long hold-off, when asked for, is counted here while the
   // sender keeps offering beats, so the unit fills up and drops req_ready.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end else if ($urandom_range(99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Register write as a setup phase and an access phase, then a pause with psel
   // low, so back-to-back writes never lower and raise psel in the same step.
   task automatic csr_write(input int index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] ds, input logic [31:0] ss,
                            input logic [31:0] trans, input logic [31:0] half,
                            input logic [31:0] steps, input logic [31:0] thr,
                            input logic [31:0] tol);
      csr_write(CSR_DS_PERIOD, ds);
      csr_write(CSR_SS_PERIOD, ss);
      csr_write(CSR_TRANS_DS_PERIOD, trans);
      csr_write(CSR_HALF_RECOMPUTE, half);
      csr_write(CSR_STEPS_BEFORE_DS, steps);
      csr_write(CSR_VEL_THRESHOLD, thr);
      csr_write(CSR_TIME_TOLERANCE, tol);
      cfg_thr = thr[14:0];
      span_us = longint'(ds[23:0]) + longint'(ss[23:0]) + longint'(trans[23:0]) +
                longint'(half[23:0]);
      settings_done++;
   endtask

   // Offers one beat and holds it until accepted; valid then either stays high
   // for the next beat or drops for a random gap.
   task automatic send_beat(input req_type b);
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [31:0] t, input logic [31:0] h,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] yaw);
      req_type b;
      b.sample_time   = t;
      b.ds_limit_time = h;
      b.vel_x         = x;
      b.vel_y         = y;
      b.vel_yaw       = yaw;
      send_beat(b);
   endtask

   // Stop offering beats, wait for every predicted result, then let the
   // pipeline settle before touching the registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input int k);
      case (k)
         0: write_all(0, 0, 0, 0, 0, 0, 0);
         1: write_all(2000, 8000, 1000, 500, 3, 100, 10);
         2: begin
            // All ones: every register keeps only its own width. The write past
            // the map must leave all of them alone.
            write_all('1, '1, '1, '1, '1, '1, '1);
            csr_write(CsrUnmapped, 32'h0);
         end
         3: write_all(10000000, 10000000, 10000000, 10000000, 255, 32767, 65535);
         SettingCount - 1:
            write_all(DsPeriodReset, SsPeriodReset, TransDsPeriodReset,
                      HalfRecomputeReset, StepsBeforeDsReset, VelThresholdReset,
                      TimeToleranceReset);
         default:
            write_all($urandom_range(0, 300000), $urandom_range(0, 1500000),
                      $urandom_range(0, 300000), $urandom_range(0, 100000),
                      $urandom_range(0, 6), $urandom_range(0, 3000),
                      $urandom_range(0, 65535));
      endcase
   endtask

   // Walking sequences: runs of beats with or without a velocity reference and
   // a sample time that moves forward by a fraction of one walking cycle, so
   // that all phase moves keep happening. A few beats are pure noise and do
   // not disturb the running time.
   task automatic run_random(input int count);
      req_type     b;
      int          run_left;
      bit          run_moving;
      int          which;
      int          pick;
      int unsigned step_max;
      run_left = 0;
      step_max = int'(span_us / 4) + 1;
      repeat (count) begin
         if (run_left == 0) begin
            run_left   = $urandom_range(3, 40);
            run_moving = ($urandom_range(99) < 65);
         end
         run_left--;
         if ($urandom_range(99) < 6) begin
            b.sample_time   = $urandom;
            b.ds_limit_time = $urandom;
            b.vel_x         = 16'($urandom);
            b.vel_y         = 16'($urandom);
            b.vel_yaw       = 16'($urandom);
         end else begin
            now_us        = later(now_us, $urandom_range(0, step_max));
            b.sample_time = now_us;
            pick          = $urandom_range(99);
            if (pick < 70)
               b.ds_limit_time = later(now_us, $urandom_range(0, int'(span_us)));
            else if (pick < 85)
               b.ds_limit_time = now_us - $urandom_range(0, 1000);
            else
               b.ds_limit_time = $urandom;
            which     = $urandom_range(0, 2);
            b.vel_x   = pick_vel(run_moving && (which == 0 || $urandom_range(0, 1) == 1));
            b.vel_y   = pick_vel(run_moving && (which == 1 || $urandom_range(0, 1) == 1));
            b.vel_yaw = pick_vel(run_moving && (which == 2 || $urandom_range(0, 1) == 1));
         end
         send_beat(b);
      end
   endtask

   initial begin : stimulus
      req_type     b;
      int          pick;
      int unsigned back;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_thr     = VelThresholdReset;
      span_us     = longint'(DsPeriodReset) + longint'(SsPeriodReset) +
                    longint'(TransDsPeriodReset) + longint'(HalfRecomputeReset);
      now_us      = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed walk at the reset register values: threshold boundaries in
      // each component, the most negative velocity, standing to walking, two
      // steps counted down, back to standing, a limit pulled in to the horizon,
      // and extreme times and horizons.
      send_fields(0, 0, 0, 0, 0);
      send_fields(0, 32'hFFFF_FFFF, 16'sh8000, 0, 0);
      send_fields(50000, 0, 16'sd1, -16'sd1, 0);
      send_fields(50000, 0, 0, 0, 16'sd2);
      send_fields(900000, 900000, 0, 16'sd1, 0);
      send_fields(900002, 900000, 0, 0, -16'sd1);
      send_fields(1650000, 0, 0, 0, 0);
      send_fields(2450000, 0, 0, 0, 0);
      send_fields(2450000, 0, 0, 16'sd32767, 0);
      send_fields(2450000, 2450000, -16'sd2, 0, 0);
      send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, -16'sd32767);
      send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      send_fields(32'hFFFF_FFFF, 0, -16'sd2, 0, 0);
      send_fields(0, 32'hFFFF_FFFF, 16'sd32767, 16'sh8000, 16'sd32767);
      send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh8000, 16'sh8000, 16'sh8000);
      send_fields(32'h5555_5555, 32'hAAAA_AAAA, 16'sh5555, 16'shAAAA, 16'sh5555);

      // Random walking under a series of register settings, each entered only
      // once the unit has returned every result.
      for (int k = 0; k < SettingCount; k++) begin
         wait_idle();
         apply_setting(k);
         req_gap_pct   = (k % 3 == 0) ? 0 : 30;
         rsp_stall_pct = (k % 4 == 2) ? 0 : 25;
         // Restart the time line just behind the current limit so steps follow
         // at once; sometimes near the top of the time range, where sums stick.
         pick = $urandom_range(99);
         if (k == 2 || pick < 15) begin
            now_us = 32'hFFFF_FFFF - $urandom_range(0, 4000000);
         end else if (pick < 25) begin
            now_us = '0;
         end else begin
            back   = $urandom_range(0, int'(span_us / 2));
            now_us = (predicted_limit > back) ? predicted_limit - back : '0;
         end
         if (k == 1) begin
            // Long result stall against a sender that never pauses.
            req_gap_pct  = 0;
            hold_request = 1'b1;
         end
         run_random(RandomBeats / SettingCount);
      end

      // Standing still: the switch point is out of reach and no reference is
      // ever given, so only the instant count moves.
      wait_idle();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      write_all(DsPeriodReset, SsPeriodReset, TransDsPeriodReset, 32'h00FF_FFFF,
                StepsBeforeDsReset, 32'h7FFF, TimeToleranceReset);
      repeat (SoakBeats) begin
         b.sample_time   = '0;
         b.ds_limit_time = $urandom;
         b.vel_x         = pick_vel(1'b0);
         b.vel_y         = pick_vel(1'b0);
         b.vel_yaw       = pick_vel(1'b0);
         send_beat(b);
      end

      // Zero periods and the latest sample time: a foot swap on every beat once in single support.
      wait_idle();
      write_all(0, 0, 0, 0, 0, 0, 0);
      repeat (SoakBeats) begin
         b.sample_time   = '1;
         b.ds_limit_time = $urandom;
         b.vel_x         = pick_vel(1'b1);
         b.vel_y         = pick_vel($urandom_range(0, 1) == 1);
         b.vel_yaw       = pick_vel($urandom_range(0, 1) == 1);
         send_beat(b);
      end

      wait_idle();
      $display("Run covered %0d request beats under %0d register settings, %0d phase moves.",
               beats_sent, settings_done, transitions);
      $display("Included a %0d-cycle result stall, drains before every setting change,",
               HoldCycles);
      $display("a standstill with the switch point out of reach and a run of foot swaps.");
      if (mismatches == 0 && outstanding == 0)
         $display("PASS gait_support_phase_fsm_unit");
      else
         $display("FAIL gait_support_phase_fsm_unit");
      $finish;
   end

endmodule
